@@ rtl/abc_pkg.sv @@
package abc_pkg;

	localparam int unsigned POSITION_WIDTH  = 32;
	localparam int unsigned FIELD_WIDTH     = 32;
	localparam int unsigned THRESHOLD_WIDTH = 31;
	localparam int unsigned COUNT_WIDTH     = 32;

	typedef enum logic [2:0] {
		KIND_NONE        = 3'd0,
		KIND_JOIN        = 3'd1,
		KIND_ORIENTATION = 3'd2,
		KIND_ORDER       = 3'd3,
		KIND_DISTANCE    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] query_id;
		logic [FIELD_WIDTH-1:0] reference_id;
		logic [FIELD_WIDTH-1:0] ref_position;
		logic [FIELD_WIDTH-1:0] query_position;
		logic [FIELD_WIDTH-1:0] ref_align_length;
		logic [FIELD_WIDTH-1:0] query_align_length;
		logic                   ref_reverse;
		logic                   query_reverse;
	} req_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] total_count;
		logic [COUNT_WIDTH-1:0] join_count;
		logic [COUNT_WIDTH-1:0] orientation_count;
		logic [COUNT_WIDTH-1:0] order_count;
		logic [COUNT_WIDTH-1:0] distance_count;
	} counts_t;

	typedef struct packed {
		logic                   is_breakpoint;
		kind_t                  kind;
		logic [COUNT_WIDTH-1:0] total_count;
		logic [COUNT_WIDTH-1:0] join_count;
		logic [COUNT_WIDTH-1:0] orientation_count;
		logic [COUNT_WIDTH-1:0] order_count;
		logic [COUNT_WIDTH-1:0] distance_count;
	} res_t;

	typedef struct packed {
		logic  update;
		kind_t kind;
	} tally_t;

endpackage

@@ rtl/abc_classify.sv @@
module abc_classify #(
	parameter int unsigned POSITION_WIDTH = abc_pkg::POSITION_WIDTH
) (
	input  logic                                 prev_valid,
	input  abc_pkg::req_t                        prev,
	input  abc_pkg::req_t                        cur,
	input  logic [abc_pkg::THRESHOLD_WIDTH-1:0]  threshold,
	output abc_pkg::kind_t                       kind
);

	localparam int unsigned EW = (POSITION_WIDTH < abc_pkg::FIELD_WIDTH) ?
		POSITION_WIDTH : abc_pkg::FIELD_WIDTH;
	localparam int unsigned AW = EW + 3;
	localparam int unsigned CW = (AW > abc_pkg::THRESHOLD_WIDTH) ?
		AW : abc_pkg::THRESHOLD_WIDTH;

	logic signed [AW-1:0] cur_rpos;
	logic signed [AW-1:0] cur_qpos;
	logic signed [AW-1:0] prev_rpos;
	logic signed [AW-1:0] prev_qpos;
	logic signed [AW-1:0] prev_rlen;
	logic signed [AW-1:0] prev_qlen;
	logic signed [AW-1:0] dr;
	logic signed [AW-1:0] dq;
	logic signed [AW-1:0] diff;
	logic        [AW-1:0] mag;
	logic        [CW-1:0] mag_w;
	logic        [CW-1:0] thr_w;
	logic                 same_group;
	logic                 orient_bad;
	logic                 order_bad;
	logic                 dist_bad;

	assign cur_rpos  = signed'({3'b000, cur.ref_position[EW-1:0]});
	assign cur_qpos  = signed'({3'b000, cur.query_position[EW-1:0]});
	assign prev_rpos = signed'({3'b000, prev.ref_position[EW-1:0]});
	assign prev_qpos = signed'({3'b000, prev.query_position[EW-1:0]});
	assign prev_rlen = signed'({3'b000, prev.ref_align_length[EW-1:0]});
	assign prev_qlen = signed'({3'b000, prev.query_align_length[EW-1:0]});

	assign dr    = cur_rpos - prev_rpos + prev_rlen;
	assign dq    = cur_qpos - prev_qpos + prev_qlen;
	assign diff  = dr - dq;
	assign mag   = diff[AW-1] ? unsigned'(-diff) : unsigned'(diff);
	assign mag_w = CW'(mag);
	assign thr_w = CW'(threshold);

	assign same_group = prev_valid && (prev.query_id == cur.query_id);
	assign orient_bad = (prev.ref_reverse ^ cur.ref_reverse) !=
		(prev.query_reverse ^ cur.query_reverse);
	assign order_bad  = (prev.ref_position[EW-1:0] >= cur.ref_position[EW-1:0]) &&
		(prev.ref_reverse == prev.query_reverse);
	assign dist_bad   = mag_w > thr_w;

	always_comb begin
		kind = abc_pkg::KIND_NONE;
		if (same_group) begin
			if (prev.reference_id != cur.reference_id) begin
				kind = abc_pkg::KIND_JOIN;
			end else if (orient_bad) begin
				kind = abc_pkg::KIND_ORIENTATION;
			end else if (order_bad) begin
				kind = abc_pkg::KIND_ORDER;
			end else if (dist_bad) begin
				kind = abc_pkg::KIND_DISTANCE;
			end
		end
	end

endmodule

@@ rtl/abc_counters.sv @@
module abc_counters (
	input  logic             clk,
	input  logic             arst_n,
	input  abc_pkg::tally_t  tally,
	output abc_pkg::counts_t counts_next
);

	abc_pkg::counts_t counts_q;

	function automatic logic [abc_pkg::COUNT_WIDTH-1:0] sat_inc(
		input logic [abc_pkg::COUNT_WIDTH-1:0] c
	);
		return (&c) ? c : c + abc_pkg::COUNT_WIDTH'(1);
	endfunction

	always_comb begin
		counts_next = counts_q;
		case (tally.kind)
			abc_pkg::KIND_JOIN: begin
				counts_next.join_count = sat_inc(counts_q.join_count);
			end
			abc_pkg::KIND_ORIENTATION: begin
				counts_next.orientation_count = sat_inc(counts_q.orientation_count);
			end
			abc_pkg::KIND_ORDER: begin
				counts_next.order_count = sat_inc(counts_q.order_count);
			end
			abc_pkg::KIND_DISTANCE: begin
				counts_next.distance_count = sat_inc(counts_q.distance_count);
			end
			default: begin
				counts_next = counts_q;
			end
		endcase
		if (tally.kind != abc_pkg::KIND_NONE) begin
			counts_next.total_count = sat_inc(counts_q.total_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (tally.update) begin
			counts_q <= counts_next;
		end
	end

endmodule

@@ rtl/alignment_breakpoint_classifier_top.sv @@
// Alignment breakpoint classifier.
// Request channel: req carries one alignment record, accepted at a rising edge
// with req_valid high and req_stall low. Records arrive sorted by query id.
// Result channel: res carries the verdict for that record and the five
// saturating counters after it, taken at an edge with res_valid high and
// res_stall low. Every request gives exactly one result, in order.
// A result passes first through the request register, then through the result
// register, before it can be taken. Throughput is one request per cycle while
// res_stall is low; the whole comparison against the previous record and the
// counter update sit in the single combinational step between those registers.
// cfg_wr_en writes cfg_wr_data into the distance threshold at the next edge;
// write it only while no request is in flight.
// Reset clears the threshold, the counters, the previous record and both
// pipeline stages; the first record after reset starts a new group.
// When res_stall is held the result holds, one more request may enter the
// request register, and then req_stall rises until the result is taken.
module alignment_breakpoint_classifier_top #(
	parameter int unsigned POSITION_WIDTH = abc_pkg::POSITION_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  abc_pkg::req_t                       req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output abc_pkg::res_t                       res,
	input  logic                                cfg_wr_en,
	input  logic [abc_pkg::THRESHOLD_WIDTH-1:0] cfg_wr_data
);

	logic [abc_pkg::THRESHOLD_WIDTH-1:0] thr_q;
	logic                                valid_s1;
	abc_pkg::req_t                       item_s1;
	logic                                valid_s2;
	abc_pkg::res_t                       res_s2;
	logic                                prev_valid_q;
	abc_pkg::req_t                       prev_q;
	logic                                advance;
	abc_pkg::kind_t                      kind;
	abc_pkg::tally_t                     tally;
	abc_pkg::counts_t                    counts_next;

	assign advance   = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	assign tally.update = advance;
	assign tally.kind   = kind;

	abc_classify #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_classify (
		.prev_valid(prev_valid_q),
		.prev      (prev_q),
		.cur       (item_s1),
		.threshold (thr_q),
		.kind      (kind)
	);

	abc_counters u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.tally      (tally),
		.counts_next(counts_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
			if (req_valid) begin
				item_s1 <= req;
			end
		end
	end

	// previous record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_q       <= '0;
		end else if (advance) begin
			prev_valid_q <= 1'b1;
			prev_q       <= item_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else if (advance) begin
			valid_s2                 <= 1'b1;
			res_s2.is_breakpoint     <= (kind != abc_pkg::KIND_NONE);
			res_s2.kind              <= kind;
			res_s2.total_count       <= counts_next.total_count;
			res_s2.join_count        <= counts_next.join_count;
			res_s2.orientation_count <= counts_next.orientation_count;
			res_s2.order_count       <= counts_next.order_count;
			res_s2.distance_count    <= counts_next.distance_count;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

endmodule

@@ bench/alignment_breakpoint_classifier_top_test.sv @@
module alignment_breakpoint_classifier_top_test;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                req_valid = 1'b0;
	logic                                req_stall;
	abc_pkg::req_t                       req = '0;
	logic                                res_valid;
	logic                                res_stall = 1'b0;
	abc_pkg::res_t                       res;
	logic                                cfg_wr_en = 1'b0;
	logic [abc_pkg::THRESHOLD_WIDTH-1:0] cfg_wr_data = '0;

	bit                                  steady = 1'b0;
	int                                  faults = 0;
	abc_pkg::res_t                       awaited_verdicts[$];

	logic                                have_last = 1'b0;
	abc_pkg::req_t                       last_rec = '0;
	abc_pkg::counts_t                    tally = '0;
	logic [abc_pkg::THRESHOLD_WIDTH-1:0] threshold_now = '0;

	alignment_breakpoint_classifier_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic longint widen(input logic [31:0] v);
		return longint'({32'b0, v});
	endfunction

	function automatic logic [abc_pkg::COUNT_WIDTH-1:0] bump(
			input logic [abc_pkg::COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic abc_pkg::res_t classify_record(input abc_pkg::req_t r);
		abc_pkg::kind_t k;
		longint         ref_gap;
		longint         qry_gap;
		longint         skew;
		abc_pkg::res_t  v;
		k = abc_pkg::KIND_NONE;
		if (have_last && last_rec.query_id == r.query_id) begin
			if (last_rec.reference_id != r.reference_id) begin
				k = abc_pkg::KIND_JOIN;
			end else if ((last_rec.ref_reverse ^ r.ref_reverse) !=
					(last_rec.query_reverse ^ r.query_reverse)) begin
				k = abc_pkg::KIND_ORIENTATION;
			end else if (last_rec.ref_position >= r.ref_position &&
					last_rec.ref_reverse == last_rec.query_reverse) begin
				k = abc_pkg::KIND_ORDER;
			end else begin
				ref_gap = widen(r.ref_position) - widen(last_rec.ref_position)
					+ widen(last_rec.ref_align_length);
				qry_gap = widen(r.query_position) - widen(last_rec.query_position)
					+ widen(last_rec.query_align_length);
				skew = ref_gap - qry_gap;
				if (skew < 0)
					skew = -skew;
				if (skew > widen({1'b0, threshold_now}))
					k = abc_pkg::KIND_DISTANCE;
			end
		end
		if (k != abc_pkg::KIND_NONE) begin
			tally.total_count = bump(tally.total_count);
			case (k)
				abc_pkg::KIND_JOIN:
					tally.join_count = bump(tally.join_count);
				abc_pkg::KIND_ORIENTATION:
					tally.orientation_count = bump(tally.orientation_count);
				abc_pkg::KIND_ORDER:
					tally.order_count = bump(tally.order_count);
				default:
					tally.distance_count = bump(tally.distance_count);
			endcase
		end
		have_last = 1'b1;
		last_rec = r;
		v.is_breakpoint = (k != abc_pkg::KIND_NONE);
		v.kind = k;
		v.total_count = tally.total_count;
		v.join_count = tally.join_count;
		v.orientation_count = tally.orientation_count;
		v.order_count = tally.order_count;
		v.distance_count = tally.distance_count;
		return v;
	endfunction

	function automatic abc_pkg::req_t make_record(input logic [31:0] qid, rid, rpos, qpos,
			rlen, qlen, input logic rr, qr);
		abc_pkg::req_t r;
		r.query_id = qid;
		r.reference_id = rid;
		r.ref_position = rpos;
		r.query_position = qpos;
		r.ref_align_length = rlen;
		r.query_align_length = qlen;
		r.ref_reverse = rr;
		r.query_reverse = qr;
		return r;
	endfunction

	function automatic logic [31:0] span();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5000) : $urandom;
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic abc_pkg::req_t fresh_record();
		return make_record($urandom, $urandom_range(0, 3), $urandom, $urandom, span(), span(),
			coin(), coin());
	endfunction

	function automatic abc_pkg::req_t follow_record(input abc_pkg::req_t p);
		abc_pkg::req_t n;
		logic [31:0]   skew;
		int            r;
		n = p;
		if ($urandom_range(0, 99) < 8)
			n.reference_id = $urandom_range(0, 3);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			n.ref_reverse = ~p.ref_reverse;
			n.query_reverse = ~p.query_reverse;
		end else if (r < 50) begin
			n.query_reverse = ~p.query_reverse;
		end
		if ($urandom_range(0, 99) < 85)
			n.ref_position = p.ref_position + p.ref_align_length + $urandom_range(0, 2000);
		else
			n.ref_position = p.ref_position - $urandom_range(0, 2000);
		r = $urandom_range(0, 99);
		if (r < 40)
			skew = {1'b0, threshold_now} + $urandom_range(0, 2) - 1;
		else if (r < 85)
			skew = $urandom_range(0, 20);
		else
			skew = $urandom;
		if ($urandom_range(0, 1))
			skew = -skew;
		n.query_position = n.ref_position - p.ref_position + p.ref_align_length
			+ p.query_position - p.query_align_length + skew;
		n.ref_align_length = span();
		n.query_align_length = span();
		return n;
	endfunction

	task automatic send_record(input abc_pkg::req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		awaited_verdicts.push_back(classify_record(r));
	endtask

	task automatic quiesce();
		req_valid <= 1'b0;
		while (awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [abc_pkg::THRESHOLD_WIDTH-1:0] value);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		threshold_now = value;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin : check_verdicts
		abc_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_verdicts.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, res);
				faults++;
			end else begin
				want = awaited_verdicts.pop_front();
				check_field("is_breakpoint", want.is_breakpoint, res.is_breakpoint);
				check_field("kind", want.kind, res.kind);
				check_field("total_count", want.total_count, res.total_count);
				check_field("join_count", want.join_count, res.join_count);
				check_field("orientation_count", want.orientation_count,
					res.orientation_count);
				check_field("order_count", want.order_count, res.order_count);
				check_field("distance_count", want.distance_count, res.distance_count);
			end
		end
	end

	initial begin : receiver_stalls
		int hold;
		forever begin
			@(posedge clk);
			hold = pick_gap();
			if (hold == 0) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic test_classification_order();
		send_record(make_record('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
		send_record(make_record('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
		send_record(make_record('1, '1, '1, '1, '1, '1, 1'b1, 1'b1));
		send_record(make_record('1, '0, '1, '1, '1, '1, 1'b1, 1'b1));
		send_record(make_record('1, '0, 100, 100, 10, 10, 1'b1, 1'b0));
		send_record(make_record('1, '0, 50, 200, 10, 10, 1'b1, 1'b0));
		send_record(make_record('1, '0, 60, 210, 5, 5, 1'b1, 1'b0));
	endtask

	task automatic test_threshold_extremes();
		write_threshold('1);
		send_record(make_record(7, 3, '0, '0, '0, '0, 1'b0, 1'b0));
		send_record(make_record(7, 3, 32'h7FFF_FFFF, '0, '0, '0, 1'b0, 1'b0));
		send_record(make_record(8, 3, '0, '0, '0, '0, 1'b1, 1'b0));
		send_record(make_record(8, 3, 32'h8000_0000, '0, '0, '0, 1'b1, 1'b0));
		send_record(make_record(8, 3, '0, '1, '1, '1, 1'b1, 1'b0));
		send_record(make_record(8, 3, '1, '0, '0, '0, 1'b1, 1'b0));
		send_record(make_record(8, 4, 5, '0, '0, '0, 1'b0, 1'b0));
		send_record(make_record(8, 4, '0, '0, '0, '0, 1'b1, 1'b1));
		send_record(make_record(8, 4, '0, '0, '0, '0, 1'b0, 1'b1));
	endtask

	task automatic run_random_groups(input logic [abc_pkg::THRESHOLD_WIDTH-1:0] value,
			input int count, input bit no_idle);
		abc_pkg::req_t cur;
		abc_pkg::req_t junk;
		int            left_in_group;
		write_threshold(value);
		steady = no_idle;
		cur = fresh_record();
		left_in_group = 0;
		for (int n = 0; n < count; n++) begin
			if (left_in_group == 0 || $urandom_range(0, 99) < 5) begin
				if ($urandom_range(0, 99) < 10)
					cur = make_record(cur.query_id, $urandom_range(0, 3), $urandom, $urandom,
						span(), span(), coin(), coin());
				else
					cur = fresh_record();
				left_in_group = $urandom_range(1, 12);
			end else begin
				cur = follow_record(cur);
				left_in_group--;
			end
			if ($urandom_range(0, 99) < 10) begin
				junk = make_record($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					coin(), coin());
				if ($urandom_range(0, 1))
					junk.query_id = cur.query_id;
				send_record(junk);
			end else begin
				send_record(cur);
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_random_groups();
		run_random_groups('0, 300, 1'b0);
		run_random_groups('1, 250, 1'b0);
		run_random_groups(abc_pkg::THRESHOLD_WIDTH'($urandom_range(0, 1000)), 300, 1'b1);
		run_random_groups(abc_pkg::THRESHOLD_WIDTH'($urandom), 250, 1'b0);
		run_random_groups(1, 300, 1'b0);
		run_random_groups(abc_pkg::THRESHOLD_WIDTH'($urandom_range(0, 50)), 400, 1'b0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_classification_order();
		test_threshold_extremes();
		test_random_groups();
		quiesce();
		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(64'd12 * 64'd1_500_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
